[src/assert_macros.svh]
// assertion macros used by the checker file
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector_normalize check failed");

// next-cycle implication
`define VN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector_normalize check failed");

`endif

[src/vnorm_pkg.sv]
package vnorm_pkg;

    localparam int COMP_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int LANES     = 4;

    localparam int SQ_W   = 2 * COMP_W;
    localparam int PAIR_W = 2 * COMP_W;
    localparam int SUM_W  = 2 * COMP_W + 1;
    localparam int ROOT_W = COMP_W + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SREM_W = ROOT_W + 2;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int DREM_W = ROOT_W + 1;

    localparam int DIM_W      = 3;
    localparam int EPS_W      = 16;
    localparam int EPSQ_W     = 2 * EPS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(3);
    localparam logic [DIM_W-1:0]  DIM_THIRD  = DIM_W'(3);
    localparam logic [DIM_W-1:0]  DIM_FOURTH = DIM_W'(4);
    localparam logic [EPS_W-1:0]  EPS_RESET  = EPS_W'(1);
    localparam logic [EPSQ_W-1:0] EPSQ_RESET = EPSQ_W'(EPS_RESET) * EPSQ_W'(EPS_RESET);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMENSION = 2'd0,
        CFG_EPSILON   = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
        logic signed [COMP_W-1:0] comp_w;
    } vn_in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
        logic                     too_short;
    } vn_out_t;

    // per-item sideband that rides along the pipeline
    typedef struct packed {
        logic [LANES-1:0][COMP_W-1:0] raw;
        logic [LANES-1:0][COMP_W-1:0] mag;
        logic [LANES-1:0]             neg;
        logic                         too_short;
    } vn_carry_t;

endpackage

[src/vnorm_root_step.sv]
module vnorm_root_step (
    input  logic [vnorm_pkg::SREM_W-1:0] rem_in,
    input  logic [vnorm_pkg::ROOT_W-1:0] root_in,
    input  logic [1:0]                   pair,
    output logic [vnorm_pkg::SREM_W-1:0] rem_out,
    output logic [vnorm_pkg::ROOT_W-1:0] root_out
);

    logic [vnorm_pkg::SREM_W-1:0] rem_sh;
    logic [vnorm_pkg::SREM_W-1:0] trial;
    logic                         fits;

    // bring down the next two radicand bits, try 4*root+1
    assign rem_sh   = {rem_in[vnorm_pkg::SREM_W-3:0], pair};
    assign trial    = {root_in, 2'b01};
    assign fits     = (rem_sh >= trial);
    assign rem_out  = fits ? (rem_sh - trial) : rem_sh;
    assign root_out = {root_in[vnorm_pkg::ROOT_W-2:0], fits};

endmodule

[src/vnorm_div_step.sv]
module vnorm_div_step (
    input  logic [vnorm_pkg::DREM_W-1:0] rem_in,
    input  logic [vnorm_pkg::ROOT_W-1:0] divisor,
    input  logic                         shift_en,
    output logic [vnorm_pkg::DREM_W-1:0] rem_out,
    output logic                         q_bit
);

    logic [vnorm_pkg::DREM_W-1:0] rem_sh;
    logic [vnorm_pkg::DREM_W-1:0] div_ext;

    // first step has weight 2^frac with no shift, since |c| <= r
    assign rem_sh  = shift_en ? {rem_in[vnorm_pkg::DREM_W-2:0], 1'b0} : rem_in;
    assign div_ext = vnorm_pkg::DREM_W'(divisor);
    assign q_bit   = (rem_sh >= div_ext);
    assign rem_out = q_bit ? (rem_sh - div_ext) : rem_sh;

endmodule

[src/vector_normalize.sv]
// vector_normalize: scales a vector of two to four signed fixed-point components
// to unit length.
// input channel vec_valid / vec_stall / vec_item carries one vector per item; the
// output channel res_valid / res_stall / res_item returns one result per item, in
// order. the config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
// dimension (index 0) and epsilon (index 1); cfg_ready is always high, and writes
// belong in idle time only.
// from acceptance to res_valid an item passes through the lane select, square and
// sum stages, the square root pipeline, the four divider lanes and the output
// register; components are signed Q4.12.
// throughput is one item per cycle while no result is stalled.
// reset clears all valid bits and sets dimension to 3 and epsilon to 1.
// a stalled result holds the whole pipeline still; vec_stall then goes high in the
// same cycle, so nothing is dropped or repeated.
module vector_normalize (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vec_valid,
    output logic                                 vec_stall,
    input  vnorm_pkg::vn_in_t                    vec_item,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output vnorm_pkg::vn_out_t                   res_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vnorm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vnorm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LANES  = vnorm_pkg::LANES;
    localparam int COMP_W = vnorm_pkg::COMP_W;
    localparam int ROOT_W = vnorm_pkg::ROOT_W;
    localparam int QUO_W  = vnorm_pkg::QUO_W;
    localparam int CMP_W  = ((QUO_W > COMP_W) ? QUO_W : COMP_W) + 1;

    logic                                en;
    logic                                res_valid_reg;
    logic [vnorm_pkg::DIM_W-1:0]         dim_reg;
    logic [vnorm_pkg::EPS_W-1:0]         eps_reg;
    logic [vnorm_pkg::EPSQ_W-1:0]        eps_sq_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= vnorm_pkg::DIM_RESET;
            eps_reg <= vnorm_pkg::EPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (vnorm_pkg::cfg_index_t'(cfg_index))
                vnorm_pkg::CFG_DIMENSION: dim_reg <= cfg_data[vnorm_pkg::DIM_W-1:0];
                vnorm_pkg::CFG_EPSILON:   eps_reg <= cfg_data[vnorm_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_sq_reg <= vnorm_pkg::EPSQ_RESET;
        end
        else
        begin
            eps_sq_reg <= vnorm_pkg::EPSQ_W'(eps_reg) * vnorm_pkg::EPSQ_W'(eps_reg);
        end
    end

    // global advance: the whole pipe moves unless the result register is held
    assign en        = !(res_valid_reg && res_stall);
    assign vec_stall = !en;

    // stage 0: lane select, sign and magnitude
    logic [LANES-1:0][COMP_W-1:0] comp_in;
    logic [LANES-1:0]             lane_use;
    vnorm_pkg::vn_carry_t         c0_next;
    vnorm_pkg::vn_carry_t         c0_reg;
    logic                         v0_reg;

    assign comp_in[0] = vec_item.comp_x;
    assign comp_in[1] = vec_item.comp_y;
    assign comp_in[2] = vec_item.comp_z;
    assign comp_in[3] = vec_item.comp_w;
    // dimension below 2 acts as 2, above 4 acts as 4
    assign lane_use   = {dim_reg >= vnorm_pkg::DIM_FOURTH, dim_reg >= vnorm_pkg::DIM_THIRD,
                         2'b11};

    always_comb
    begin
        c0_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            c0_next.raw[l] = lane_use[l] ? comp_in[l] : '0;
            c0_next.neg[l] = c0_next.raw[l][COMP_W-1];
            c0_next.mag[l] = c0_next.neg[l] ? (~c0_next.raw[l] + 1'b1) : c0_next.raw[l];
        end
    end

    // stage 1: squares
    logic [LANES-1:0][vnorm_pkg::SQ_W-1:0] sq_next;
    logic [LANES-1:0][vnorm_pkg::SQ_W-1:0] sq_reg;
    vnorm_pkg::vn_carry_t                  c1_reg;
    logic                                  v1_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sq_next[l] = vnorm_pkg::SQ_W'(c0_reg.mag[l]) * vnorm_pkg::SQ_W'(c0_reg.mag[l]);
        end
    end

    // stage 2: pair sums
    logic [1:0][vnorm_pkg::PAIR_W-1:0] ps_next;
    logic [1:0][vnorm_pkg::PAIR_W-1:0] ps_reg;
    vnorm_pkg::vn_carry_t              c2_reg;
    logic                              v2_reg;

    assign ps_next[0] = vnorm_pkg::PAIR_W'(sq_reg[0]) + vnorm_pkg::PAIR_W'(sq_reg[1]);
    assign ps_next[1] = vnorm_pkg::PAIR_W'(sq_reg[2]) + vnorm_pkg::PAIR_W'(sq_reg[3]);

    // stage 3: exact sum of squares and the short-vector test
    logic [vnorm_pkg::SUM_W-1:0] rad_next;
    logic [vnorm_pkg::SUM_W-1:0] rad_reg;
    vnorm_pkg::vn_carry_t        c3_next;
    vnorm_pkg::vn_carry_t        c3_reg;
    logic                        v3_reg;

    assign rad_next = vnorm_pkg::SUM_W'(ps_reg[0]) + vnorm_pkg::SUM_W'(ps_reg[1]);

    always_comb
    begin
        c3_next           = c2_reg;
        c3_next.too_short = (rad_next <= vnorm_pkg::SUM_W'(eps_sq_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= vec_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg  <= c0_next;
            sq_reg  <= sq_next;
            c1_reg  <= c0_reg;
            ps_reg  <= ps_next;
            c2_reg  <= c1_reg;
            rad_reg <= rad_next;
            c3_reg  <= c3_next;
        end
    end

    // square root pipeline, one root bit per stage
    logic [vnorm_pkg::SREM_W-1:0] rt_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]            rt_root_reg [ROOT_W];
    logic [vnorm_pkg::SUM_W-1:0]  rt_rad_reg  [ROOT_W];
    vnorm_pkg::vn_carry_t         rt_c_reg    [ROOT_W];
    logic                         rt_v_reg    [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        logic [vnorm_pkg::SREM_W-1:0] rem_in;
        logic [vnorm_pkg::SREM_W-1:0] rem_next;
        logic [ROOT_W-1:0]            root_in;
        logic [ROOT_W-1:0]            root_next;
        logic [vnorm_pkg::SUM_W-1:0]  rad_in;
        logic [vnorm_pkg::RAD_W-1:0]  rad_pad;
        vnorm_pkg::vn_carry_t         c_in;
        logic                         v_in;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad_reg;
            assign c_in    = c3_reg;
            assign v_in    = v3_reg;
        end
        else
        begin : g_later
            assign rem_in  = rt_rem_reg[k-1];
            assign root_in = rt_root_reg[k-1];
            assign rad_in  = rt_rad_reg[k-1];
            assign c_in    = rt_c_reg[k-1];
            assign v_in    = rt_v_reg[k-1];
        end

        assign rad_pad = vnorm_pkg::RAD_W'(rad_in);

        vnorm_root_step u_step (
            .rem_in   (rem_in),
            .root_in  (root_in),
            .pair     (rad_pad[vnorm_pkg::RAD_W-1-2*k -: 2]),
            .rem_out  (rem_next),
            .root_out (root_next)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                rt_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_rem_reg[k]  <= rem_next;
                rt_root_reg[k] <= root_next;
                rt_rad_reg[k]  <= rad_in;
                rt_c_reg[k]    <= c_in;
            end
        end
    end

    // divider pipeline, four lanes, one quotient bit per stage
    logic [LANES-1:0][vnorm_pkg::DREM_W-1:0] dv_rem_reg [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]             dv_q_reg   [QUO_W];
    logic [ROOT_W-1:0]                       dv_len_reg [QUO_W];
    vnorm_pkg::vn_carry_t                    dv_c_reg   [QUO_W];
    logic                                    dv_v_reg   [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        logic [LANES-1:0][vnorm_pkg::DREM_W-1:0] rem_in;
        logic [LANES-1:0][vnorm_pkg::DREM_W-1:0] rem_next;
        logic [LANES-1:0][QUO_W-1:0]             q_in;
        logic [LANES-1:0][QUO_W-1:0]             q_next;
        logic [LANES-1:0]                        q_bit;
        logic [ROOT_W-1:0]                       len_in;
        vnorm_pkg::vn_carry_t                    c_in;
        logic                                    v_in;

        if (k == 0)
        begin : g_first
            // a zero root only comes with a too-short item, guard it anyway
            assign len_in = (rt_root_reg[ROOT_W-1] == '0) ? ROOT_W'(1)
                                                          : rt_root_reg[ROOT_W-1];
            assign c_in   = rt_c_reg[ROOT_W-1];
            assign v_in   = rt_v_reg[ROOT_W-1];
            assign q_in   = '0;
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane_init
                assign rem_in[l] = vnorm_pkg::DREM_W'(rt_c_reg[ROOT_W-1].mag[l]);
            end
        end
        else
        begin : g_later
            assign len_in = dv_len_reg[k-1];
            assign c_in   = dv_c_reg[k-1];
            assign v_in   = dv_v_reg[k-1];
            assign q_in   = dv_q_reg[k-1];
            assign rem_in = dv_rem_reg[k-1];
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            vnorm_div_step u_step (
                .rem_in   (rem_in[l]),
                .divisor  (len_in),
                .shift_en (k != 0),
                .rem_out  (rem_next[l]),
                .q_bit    (q_bit[l])
            );
            assign q_next[l] = {q_in[l][QUO_W-2:0], q_bit[l]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[k] <= rem_next;
                dv_q_reg[k]   <= q_next;
                dv_len_reg[k] <= len_in;
                dv_c_reg[k]   <= c_in;
            end
        end
    end

    // output stage: sign, saturation, pass-through
    vnorm_pkg::vn_out_t res_next;
    vnorm_pkg::vn_out_t res_reg;

    always_comb
    begin
        logic [CMP_W-1:0]             lim_neg;
        logic [CMP_W-1:0]             lim_pos;
        logic [CMP_W-1:0]             q_ext;
        logic [CMP_W-1:0]             sat;
        logic [COMP_W-1:0]            val;
        logic [LANES-1:0][COMP_W-1:0] outv;
        vnorm_pkg::vn_carry_t         c_last;

        c_last  = dv_c_reg[QUO_W-1];
        lim_neg = CMP_W'(1) << (COMP_W - 1);
        lim_pos = lim_neg - CMP_W'(1);
        for (int l = 0; l < LANES; l++)
        begin
            q_ext = CMP_W'(dv_q_reg[QUO_W-1][l]);
            if (c_last.neg[l])
            begin
                sat = (q_ext > lim_neg) ? lim_neg : q_ext;
                val = ~sat[COMP_W-1:0] + 1'b1;
            end
            else
            begin
                sat = (q_ext > lim_pos) ? lim_pos : q_ext;
                val = sat[COMP_W-1:0];
            end
            outv[l] = c_last.too_short ? c_last.raw[l] : val;
        end
        res_next.out_x     = outv[0];
        res_next.out_y     = outv[1];
        res_next.out_z     = outv[2];
        res_next.out_w     = outv[3];
        res_next.too_short = c_last.too_short;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= dv_v_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

[src/vnorm_checker.sv]
`include "assert_macros.svh"

module vnorm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             vec_stall,
    input logic                             res_valid,
    input logic                             res_stall,
    input vnorm_pkg::vn_out_t               res_item
);

    localparam int UNIT = 1 << vnorm_pkg::FRAC_BITS;

    logic normalized;
    logic in_range;
    logic nonzero;

    assign normalized = res_valid && !res_item.too_short;
    assign in_range   = (res_item.out_x <= UNIT) && (res_item.out_x >= -UNIT) &&
                        (res_item.out_y <= UNIT) && (res_item.out_y >= -UNIT) &&
                        (res_item.out_z <= UNIT) && (res_item.out_z >= -UNIT) &&
                        (res_item.out_w <= UNIT) && (res_item.out_w >= -UNIT);
    assign nonzero    = (res_item.out_x != '0) || (res_item.out_y != '0) ||
                        (res_item.out_z != '0) || (res_item.out_w != '0);

    // a held result keeps its item
    `VN_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item))

    // the input side is only held back by a held result
    `VN_ASSERT_NOW(a_stall_cause, vec_stall, res_valid && res_stall)

    // scaled components stay within one unit
    `VN_ASSERT_NOW(a_unit_range, normalized, in_range)

    // a vector that was long enough never comes out all zero
    `VN_ASSERT_NOW(a_not_zero, normalized, nonzero)

endmodule

bind vector_normalize vnorm_checker u_vnorm_checker (.*);

[bench/tb_vector_normalize.sv]
module tb_vector_normalize;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COMP_W     = vnorm_pkg::COMP_W;
    localparam int FRAC_BITS  = vnorm_pkg::FRAC_BITS;
    localparam int LANES      = vnorm_pkg::LANES;
    localparam int DIM_W      = vnorm_pkg::DIM_W;
    localparam int EPS_W      = vnorm_pkg::EPS_W;
    localparam int CFG_DATA_W = vnorm_pkg::CFG_DATA_W;

    class norm_scoreboard;
        logic [DIM_W-1:0]   dim_reg;
        logic [EPS_W-1:0]   eps_reg;
        vnorm_pkg::vn_out_t expected_q[$];
        int unsigned        accepted;
        int unsigned        errors;

        function new();
            dim_reg  = vnorm_pkg::DIM_RESET;
            eps_reg  = vnorm_pkg::EPS_RESET;
            accepted = 0;
            errors   = 0;
        endfunction

        function void write_reg(vnorm_pkg::cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                vnorm_pkg::CFG_DIMENSION: dim_reg = data[DIM_W-1:0];
                vnorm_pkg::CFG_EPSILON:   eps_reg = data[EPS_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // works out the normalized vector for one accepted item
        function void note_vector(vnorm_pkg::vn_in_t v);
            logic signed [COMP_W-1:0] lane[LANES];
            logic signed [COMP_W-1:0] res[LANES];
            int unsigned        used;
            longint             mag;
            longint unsigned    sum, eps_sq, root, trial, q;
            vnorm_pkg::vn_out_t r;

            used   = (dim_reg < 2) ? 2 : (dim_reg > 4) ? 4 : int'(dim_reg);
            lane   = '{v.comp_x, v.comp_y, v.comp_z, v.comp_w};
            res    = '{default: '0};
            sum    = 0;
            eps_sq = longint'(eps_reg) * longint'(eps_reg);
            for (int i = 0; i < used; i++)
            begin
                mag = (lane[i] < 0) ? -longint'(lane[i]) : longint'(lane[i]);
                sum += mag * mag;
            end
            r.too_short = (sum <= eps_sq);
            if (r.too_short)
            begin
                for (int i = 0; i < used; i++)
                    res[i] = lane[i];
            end
            else
            begin
                root = 0;
                for (int b = COMP_W; b >= 0; b--)
                begin
                    trial = root | (64'd1 << b);
                    if (trial * trial <= sum)
                        root = trial;
                end
                if (root == 0)
                    root = 1;
                for (int i = 0; i < used; i++)
                begin
                    mag = (lane[i] < 0) ? -longint'(lane[i]) : longint'(lane[i]);
                    q = (longint'(mag) << FRAC_BITS) / root;
                    if (lane[i] < 0)
                    begin
                        if (q > (64'd1 << (COMP_W - 1)))
                            q = 64'd1 << (COMP_W - 1);
                        res[i] = COMP_W'(-q);
                    end
                    else
                    begin
                        if (q > (64'd1 << (COMP_W - 1)) - 1)
                            q = (64'd1 << (COMP_W - 1)) - 1;
                        res[i] = COMP_W'(q);
                    end
                end
            end
            r.out_x = res[0];
            r.out_y = res[1];
            r.out_z = res[2];
            r.out_w = res[3];
            expected_q.push_back(r);
            accepted++;
        endfunction

        function void check_result(vnorm_pkg::vn_out_t got);
            vnorm_pkg::vn_out_t exp;
            logic [COMP_W-1:0] exp_l[LANES];
            logic [COMP_W-1:0] got_l[LANES];
            string lane_name[LANES];

            lane_name = '{"out_x", "out_y", "out_z", "out_w"};
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual %h", $time, got);
                return;
            end
            exp   = expected_q.pop_front();
            exp_l = '{exp.out_x, exp.out_y, exp.out_z, exp.out_w};
            got_l = '{got.out_x, got.out_y, got.out_z, got.out_w};
            for (int i = 0; i < LANES; i++)
            begin
                if (got_l[i] !== exp_l[i])
                begin
                    errors++;
                    $display("%0t: %s expected %0d actual %0d", $time, lane_name[i],
                             $signed(exp_l[i]), $signed(got_l[i]));
                end
            end
            if (got.too_short !== exp.too_short)
            begin
                errors++;
                $display("%0t: too_short expected %b actual %b", $time,
                         exp.too_short, got.too_short);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  vec_valid = 1'b0;
    logic                  vec_stall;
    vnorm_pkg::vn_in_t     vec_item  = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    vnorm_pkg::vn_out_t    res_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    vnorm_pkg::cfg_index_t cfg_index = vnorm_pkg::CFG_DIMENSION;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    norm_scoreboard sb = new();
    bit long_hold_done = 1'b0;

    vector_normalize i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_valid (vec_valid),
        .vec_stall (vec_stall),
        .vec_item  (vec_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic vnorm_pkg::vn_in_t random_vector(logic [EPS_W-1:0] eps);
        logic [COMP_W-1:0] lane[LANES];
        logic [COMP_W-1:0] extremes[5];
        int unsigned       pick, bound, t;

        extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        pick  = $urandom_range(0, 9);
        bound = $urandom_range(1, 64);
        for (int i = 0; i < LANES; i++)
        begin
            if (pick <= 4)
                lane[i] = COMP_W'($urandom);
            else if (pick <= 6)
                lane[i] = COMP_W'($urandom_range(0, 2 * bound)) - COMP_W'(bound);
            else if (pick == 7)
                lane[i] = extremes[$urandom_range(0, 4)];
            else
                lane[i] = '0;
        end
        // length right at or just past the epsilon threshold when epsilon is below 32767
        if (pick >= 8)
        begin
            t = (eps < 32767) ? eps + (pick - 8) : $urandom_range(30000, 32767);
            lane[1] = $urandom_range(0, 1) ? COMP_W'(t) : -COMP_W'(t);
        end
        return {lane[0], lane[1], lane[2], lane[3]};
    endfunction

    task automatic send_vector(vnorm_pkg::vn_in_t item, int unsigned gap);
        if (gap != 0)
        begin
            vec_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vec_valid <= 1'b1;
        vec_item  <= item;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        sb.note_vector(item);
        @(negedge clk);
    endtask

    task automatic write_register(vnorm_pkg::cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        vec_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    initial
    begin
        logic [63:0]       directed_vec[];
        logic [DIM_W-1:0]  dim_set[];
        logic [EPS_W-1:0]  eps_set[];
        int unsigned       gap, burst;

        directed_vec = '{
            64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
            64'hFFFF_0000_0000_7FFF, 64'h0001_0001_0000_0000,
            64'h1000_0000_0000_0000, 64'h8000_0000_0000_0000,
            64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
            64'h8000_7FFF_8000_0000, 64'h3000_4000_0000_0000,
            64'hD000_C000_0000_FFFF, 64'h5555_AAAA_00FF_FF00,
            64'hAAAA_5555_FF00_00FF, 64'h0002_FFFD_0005_8000,
            64'h0000_0000_0001_8000, 64'h0000_0000_FFFE_0000
        };
        dim_set = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd5, 3'd6, 3'd4, 3'd3};
        eps_set = '{16'd0, 16'd65535, 16'd4096, 16'd300, 16'd1, 16'd32768,
                    16'd100, 16'd0, 16'd20000};
        burst = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings first: dimension three, epsilon one
        foreach (directed_vec[i])
            send_vector(vnorm_pkg::vn_in_t'(directed_vec[i]), idle_len());
        drain_pipeline();

        foreach (dim_set[p])
        begin
            write_register(vnorm_pkg::CFG_DIMENSION,
                           {(CFG_DATA_W - DIM_W)'($urandom), dim_set[p]});
            write_register(vnorm_pkg::CFG_EPSILON, eps_set[p]);
            cfg_valid <= 1'b0;
            for (int n = 0; n < 180; n++)
            begin
                if (burst != 0)
                begin
                    gap = 0;
                    burst--;
                end
                else
                begin
                    gap = idle_len();
                    if ($urandom_range(0, 29) == 0)
                        burst = $urandom_range(20, 60);
                end
                send_vector(random_vector(sb.eps_reg), gap);
            end
            drain_pipeline();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS vector_normalize");
        else
            $display("FAIL vector_normalize");
        $finish;
    end

    // result side back-pressure, with one long hold-off to fill the pipeline
    initial
    begin
        int unsigned run, hold;

        wait (rst_n);
        @(negedge clk);
        forever
        begin
            res_stall <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 30);
            repeat (run) @(negedge clk);
            // early in a block of items, so the sender keeps offering during the hold
            if (!long_hold_done && sb.accepted >= 760)
            begin
                long_hold_done = 1'b1;
                hold = 300;
            end
            else
                hold = idle_len();
            if (hold != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_item);
    end

    initial
    begin
        #20ms;
        $display("FAIL vector_normalize");
        $finish;
    end

endmodule
